// ===== hw/rtl/sorted_timer_queue_defines.svh =====
// Assertion macros for the sorted timer queue.
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH

`ifndef SYNTH
`define STQ_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("stq check failed");
`define STQ_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("stq check failed");
`else
`define STQ_ASSERT_NOW(lbl, clk, rst_n, a, c)
`define STQ_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif

`endif

// ===== hw/rtl/stq_pkg.sv =====
package stq_pkg;

    localparam int TIME_W      = 64;
    localparam int ID_W        = 6;
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = 5;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_WAKE   = 2'd2,
        CMD_SET    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_RESP,
        S_POP
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [ID_W-1:0]   id;
        logic              id_bad;
        logic [TIME_W-1:0] tval;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } op_head_t;

endpackage

// ===== hw/rtl/stq_if.sv =====
interface stq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [5:0]  sleeper_id;
    logic [63:0] wake_time;
    logic [63:0] now_time;
    logic [63:0] preempt_time;

    modport source (output valid, cmd, sleeper_id, wake_time, now_time, preempt_time,
                    input ready);
    modport sink (input valid, cmd, sleeper_id, wake_time, now_time, preempt_time,
                  output ready);
endinterface

interface stq_rsp_if;
    logic        valid;
    logic        ready;
    logic        woken_valid;
    logic [5:0]  woken_id;
    logic        preempt_expired;
    logic        front_changed;
    logic [1:0]  status;
    logic [63:0] next_wakeup;
    logic        last;

    modport source (output valid, woken_valid, woken_id, preempt_expired, front_changed,
                    status, next_wakeup, last, input ready);
    modport sink (input valid, woken_valid, woken_id, preempt_expired, front_changed,
                  status, next_wakeup, last, output ready);
endinterface

// ===== hw/rtl/stq_front.sv =====
module stq_front #(
    parameter int ID_COUNT = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    stq_req_if.sink         req,
    output stq_pkg::op_head_t head,
    input  logic            pop
);
    import stq_pkg::*;

    op_t        fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       do_pop;
    op_t        op_in;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign do_pop    = pop && (cnt_reg != 2'd0);

    always_comb
    begin
        op_in.cmd    = cmd_t'(req.cmd);
        op_in.id     = req.sleeper_id;
        op_in.id_bad = (32'(req.sleeper_id) >= ID_COUNT);
        case (cmd_t'(req.cmd))
            CMD_WAKE: op_in.tval = req.now_time;
            CMD_SET:  op_in.tval = req.preempt_time;
            default:  op_in.tval = req.wake_time;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= op_in;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.op    = fifo_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/stq_back.sv =====
`include "sorted_timer_queue_defines.svh"

module stq_back #(
    parameter int SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  stq_pkg::op_head_t head,
    output logic              pop,
    stq_rsp_if.source         rsp
);
    import stq_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [TIME_W-1:0] wake_reg [SLOTS];
    logic [ID_W-1:0]   sid_reg  [SLOTS];
    logic [CNT_W-1:0]  count_reg;
    logic [TIME_W-1:0] deadline_reg;
    state_t            state_reg, state_next;
    op_t               cur_reg;
    logic [CNT_W-1:0]  pos_reg, due_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hitpos_reg;
    logic              expired_reg, front_reg, first_reg;
    status_t           status_reg;
    logic [TIME_W-1:0] earliest_reg;
    logic [RES_W-1:0]  rem_reg;

    logic              out_valid_reg;
    logic              out_woken_valid_reg;
    logic [ID_W-1:0]   out_woken_id_reg;
    logic              out_expired_reg, out_front_reg, out_last_reg;
    status_t           out_status_reg;
    logic [TIME_W-1:0] out_next_reg;

    logic [SLOTS-1:0]  lt, le, match;
    logic [IDX_W-1:0]  hitpos;
    logic [CNT_W-1:0]  take;
    logic [TIME_W-1:0] head_after, earliest_now;
    logic              slot_free, out_load;
    logic              do_insert, do_remove, do_pop, id_err;
    logic              full;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign full      = (count_reg == CNT_W'(SLOTS));
    assign id_err    = cur_reg.id_bad;
    assign do_insert = (cur_reg.cmd == CMD_ADD) && !id_err && !hit_reg && !full;
    assign do_remove = (cur_reg.cmd == CMD_CANCEL) && !id_err && hit_reg;

    always_comb
    begin
        hitpos = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            lt[i]    = (i < int'(count_reg)) && (wake_reg[i] < cur_reg.tval);
            le[i]    = (i < int'(count_reg)) && (wake_reg[i] <= cur_reg.tval);
            match[i] = (i < int'(count_reg)) && (sid_reg[i] == cur_reg.id);
        end
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hitpos = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        take = (32'(due_reg) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : due_reg;
        head_after = (take < count_reg) ? wake_reg[take[IDX_W-1:0]] : TIME_MAX;
        earliest_now = (count_reg != '0 && wake_reg[0] < deadline_reg)
                     ? wake_reg[0] : deadline_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (head.valid) state_next = S_SCAN;
            S_SCAN: state_next = S_EXEC;
            S_EXEC:
            begin
                if (cur_reg.cmd == CMD_WAKE && take != '0)
                    state_next = S_POP;
                else
                    state_next = S_RESP;
            end
            S_RESP: if (slot_free) state_next = S_IDLE;
            S_POP:  if (slot_free && rem_reg == RES_W'(1)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        out_load = 1'b0;
        do_pop   = 1'b0;
        unique case (state_reg)
            S_IDLE: pop = head.valid;
            S_RESP: out_load = slot_free;
            S_POP:
            begin
                out_load = slot_free;
                do_pop   = slot_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            deadline_reg  <= TIME_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                if (do_insert)
                    count_reg <= count_reg + CNT_W'(1);
                else if (do_remove)
                    count_reg <= count_reg - CNT_W'(1);
                if (cur_reg.cmd == CMD_SET)
                    deadline_reg <= cur_reg.tval;
                else if (cur_reg.cmd == CMD_WAKE && expired_reg)
                    deadline_reg <= TIME_MAX;
            end
            if (do_pop)
                count_reg <= count_reg - CNT_W'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head.op;
        if (state_reg == S_SCAN)
        begin
            pos_reg     <= CNT_W'($countones(lt));
            due_reg     <= CNT_W'($countones(le));
            hit_reg     <= |match;
            hitpos_reg  <= hitpos;
            expired_reg <= (deadline_reg <= cur_reg.tval);
        end
        if (state_reg == S_EXEC)
        begin
            rem_reg      <= RES_W'(take);
            first_reg    <= 1'b1;
            earliest_reg <= (expired_reg || head_after < deadline_reg)
                          ? ((expired_reg && head_after == TIME_MAX) ? TIME_MAX :
                             (head_after < deadline_reg || expired_reg) ? head_after
                             : deadline_reg)
                          : deadline_reg;
            front_reg    <= 1'b0;
            status_reg   <= ST_OK;
            if (cur_reg.cmd == CMD_ADD)
            begin
                if (id_err)
                    status_reg <= ST_MISSING;
                else if (hit_reg)
                    status_reg <= ST_DUP;
                else if (full)
                    status_reg <= ST_FULL;
                else
                    front_reg <= (pos_reg == '0);
            end
            else if (cur_reg.cmd == CMD_CANCEL)
            begin
                if (id_err || !hit_reg)
                    status_reg <= ST_MISSING;
                else
                    front_reg <= (hitpos_reg == '0);
            end
            if (do_insert)
            begin
                for (int i = 1; i < SLOTS; i++)
                begin
                    if (CNT_W'(i) > pos_reg)
                    begin
                        wake_reg[i] <= wake_reg[i-1];
                        sid_reg[i]  <= sid_reg[i-1];
                    end
                end
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (CNT_W'(i) == pos_reg)
                    begin
                        wake_reg[i] <= cur_reg.tval;
                        sid_reg[i]  <= cur_reg.id;
                    end
                end
            end
            else if (do_remove)
            begin
                for (int i = 0; i < SLOTS - 1; i++)
                begin
                    if (IDX_W'(i) >= hitpos_reg)
                    begin
                        wake_reg[i] <= wake_reg[i+1];
                        sid_reg[i]  <= sid_reg[i+1];
                    end
                end
            end
        end
        if (do_pop)
        begin
            rem_reg   <= rem_reg - RES_W'(1);
            first_reg <= 1'b0;
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                wake_reg[i] <= wake_reg[i+1];
                sid_reg[i]  <= sid_reg[i+1];
            end
        end
        if (out_load)
        begin
            if (state_reg == S_POP)
            begin
                out_woken_valid_reg <= 1'b1;
                out_woken_id_reg    <= sid_reg[0];
                out_expired_reg     <= first_reg && expired_reg;
                out_front_reg       <= 1'b1;
                out_status_reg      <= ST_OK;
                out_next_reg        <= earliest_reg;
                out_last_reg        <= (rem_reg == RES_W'(1));
            end
            else
            begin
                out_woken_valid_reg <= 1'b0;
                out_woken_id_reg    <= '0;
                out_expired_reg     <= (cur_reg.cmd == CMD_WAKE) && expired_reg;
                out_front_reg       <= front_reg;
                out_status_reg      <= status_reg;
                out_next_reg        <= earliest_now;
                out_last_reg        <= 1'b1;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.woken_valid     = out_woken_valid_reg;
    assign rsp.woken_id        = out_woken_id_reg;
    assign rsp.preempt_expired = out_expired_reg;
    assign rsp.front_changed   = out_front_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.next_wakeup     = out_next_reg;
    assign rsp.last            = out_last_reg;

    `STQ_ASSERT_NOW(a_pop_nonempty, clk, rst_n, state_reg == S_POP, count_reg != '0)
    `STQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(SLOTS))
    `STQ_ASSERT_NEXT(a_deadline_clear, clk, rst_n,
        state_reg == S_EXEC && cur_reg.cmd == CMD_WAKE && expired_reg,
        deadline_reg == TIME_MAX)

endmodule

// ===== hw/rtl/sorted_timer_queue.sv =====
// channel | dir | payload
// req     | in  | cmd, sleeper_id, wake_time, now_time, preempt_time
// rsp     | out | woken_valid, woken_id, preempt_expired, front_changed,
//         |     | status, next_wakeup, last
// The sequencer takes an item through its take, scan, update and respond steps.
// A wakeup that releases sleepers sends one rsp beat per sleeper, up to 16, in place of a single response.
// A stalled rsp holds the sequencer in its response step.
// A two-beat command queue lets req run ahead while rsp is stalled.
// Reset empties the queue and sets the deadline to all ones; no clearing pass.
module sorted_timer_queue #(
    parameter int SLOTS    = 16,
    parameter int ID_COUNT = 64
) (
    input logic      clk,
    input logic      rst_n,
    stq_req_if.sink  req,
    stq_rsp_if.source rsp
);
    import stq_pkg::*;

    op_head_t head;
    logic     pop;

    stq_front #(.ID_COUNT(ID_COUNT)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    stq_back #(.SLOTS(SLOTS)) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

// ===== test/stq_checker.sv =====
module stq_checker
    import stq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    stq_req_if.sink     req,
    stq_rsp_if.sink     rsp,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic              woken_valid;
        logic [ID_W-1:0]   woken_id;
        logic              preempt_expired;
        logic              front_changed;
        status_t           status;
        logic [TIME_W-1:0] next_wakeup;
        logic              last;
    } wake_rsp_t;

    localparam int NSLOT = 16;

    logic [TIME_W-1:0] q_time [NSLOT];
    logic [ID_W-1:0]   q_id   [NSLOT];
    int                q_len;
    logic [TIME_W-1:0] deadline;
    wake_rsp_t         want_q [$];

    function automatic logic [TIME_W-1:0] soonest();
        soonest = deadline;
        if (q_len > 0 && q_time[0] < soonest)
            soonest = q_time[0];
    endfunction

    function automatic int locate(logic [ID_W-1:0] id);
        locate = -1;
        for (int i = q_len - 1; i >= 0; i--)
            if (q_id[i] == id)
                locate = i;
    endfunction

    function automatic void drop_at(int pos);
        for (int i = pos; i + 1 < q_len; i++)
        begin
            q_time[i] = q_time[i + 1];
            q_id[i]   = q_id[i + 1];
        end
        q_len--;
    endfunction

    task automatic apply_cmd(cmd_t c, logic [ID_W-1:0] id, logic [TIME_W-1:0] wt,
                             logic [TIME_W-1:0] nt, logic [TIME_W-1:0] pt);
        logic [ID_W-1:0] popped [$];
        status_t   st;
        logic      fr;
        logic      exp;
        int        pos;
        wake_rsp_t r;
        st  = ST_OK;
        fr  = 1'b0;
        exp = 1'b0;
        case (c)
            CMD_ADD:
            begin
                if (locate(id) >= 0)
                    st = ST_DUP;
                else if (q_len >= NSLOT)
                    st = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < q_len && q_time[pos] < wt)
                        pos++;
                    for (int i = q_len; i > pos; i--)
                    begin
                        q_time[i] = q_time[i - 1];
                        q_id[i]   = q_id[i - 1];
                    end
                    q_time[pos] = wt;
                    q_id[pos]   = id;
                    q_len++;
                    fr = (pos == 0);
                end
            end
            CMD_CANCEL:
            begin
                pos = locate(id);
                if (pos < 0)
                    st = ST_MISSING;
                else
                begin
                    fr = (pos == 0);
                    drop_at(pos);
                end
            end
            CMD_SET: deadline = pt;
            default:
            begin
                if (deadline <= nt)
                begin
                    exp = 1'b1;
                    deadline = TIME_MAX;
                end
                while (popped.size() < MAX_RESULTS && q_len > 0 && q_time[0] <= nt)
                begin
                    popped.push_back(q_id[0]);
                    drop_at(0);
                end
            end
        endcase
        if (popped.size() == 0)
        begin
            r = '{1'b0, '0, exp, fr, st, soonest(), 1'b1};
            want_q.push_back(r);
        end
        else
            for (int k = 0; k < popped.size(); k++)
            begin
                r = '{1'b1, popped[k], (k == 0) ? exp : 1'b0, 1'b1, ST_OK, soonest(),
                      k == popped.size() - 1};
                want_q.push_back(r);
            end
    endtask

    assign pending = want_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        wake_rsp_t w;
        if (!rst_n)
        begin
            q_len      <= 0;
            deadline   <= TIME_MAX;
            fail_count <= 0;
            want_q.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (want_q.size() == 0)
                begin
                    $error("unexpected rsp beat");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    w = want_q.pop_front();
                    if (rsp.woken_valid !== w.woken_valid || rsp.woken_id !== w.woken_id
                        || rsp.preempt_expired !== w.preempt_expired
                        || rsp.front_changed !== w.front_changed
                        || rsp.status !== w.status || rsp.next_wakeup !== w.next_wakeup
                        || rsp.last !== w.last)
                        fail_count <= fail_count + 1;
                    if (rsp.woken_valid !== w.woken_valid)
                        $error("woken_valid exp %0d got %0d", w.woken_valid, rsp.woken_valid);
                    if (rsp.woken_id !== w.woken_id)
                        $error("woken_id exp %0d got %0d", w.woken_id, rsp.woken_id);
                    if (rsp.preempt_expired !== w.preempt_expired)
                        $error("preempt_expired exp %0d got %0d", w.preempt_expired,
                               rsp.preempt_expired);
                    if (rsp.front_changed !== w.front_changed)
                        $error("front_changed exp %0d got %0d", w.front_changed,
                               rsp.front_changed);
                    if (rsp.status !== w.status)
                        $error("status exp %0d got %0d", w.status, rsp.status);
                    if (rsp.next_wakeup !== w.next_wakeup)
                        $error("next_wakeup exp %h got %h", w.next_wakeup, rsp.next_wakeup);
                    if (rsp.last !== w.last)
                        $error("last exp %0d got %0d", w.last, rsp.last);
                end
            end
            if (req.valid && req.ready)
                apply_cmd(cmd_t'(req.cmd), req.sleeper_id, req.wake_time, req.now_time,
                          req.preempt_time);
        end
    end

endmodule

// ===== test/tb_sorted_timer_queue.sv =====
module tb_sorted_timer_queue;
    import stq_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   hold_cycles;
    bit   no_idle;
    bit   drain_done;

    stq_req_if req ();
    stq_rsp_if rsp ();

    sorted_timer_queue dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    stq_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                     .fail_count(fail_count), .pending(pending));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        req.valid = 1'b0;
        req.cmd = '0;
        req.sleeper_id = '0;
        req.wake_time = '0;
        req.now_time = '0;
        req.preempt_time = '0;
        rsp.ready = 1'b0;
    end

    // rsp side: random stalls, then a long hold so the block backs up
    initial
    begin
        int n;
        @(posedge rst_n);
        while (!drain_done)
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp.ready <= 1'b0;
                hold_cycles--;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 12);
                rsp.ready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    logic [TIME_W-1:0] clock_now;

    task automatic send(cmd_t c, logic [5:0] id, logic [63:0] wt, logic [63:0] nt,
                        logic [63:0] pt);
        int n;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 12);
            req.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= c;
        req.sleeper_id <= id;
        req.wake_time <= wt;
        req.now_time <= nt;
        req.preempt_time <= pt;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rnd64();
        rnd64 = {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] near_time();
        near_time = clock_now + $urandom_range(0, 60);
    endfunction

    initial
    begin
        int r;
        logic [63:0] t;
        clock_now = 64'd1000;
        drain_done = 1'b0;
        no_idle = 1'b0;
        hold_cycles = 0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(CMD_WAKE, 6'd0, '0, 64'd0, '0);
        send(CMD_CANCEL, 6'd5, '0, '0, '0);
        send(CMD_ADD, 6'd63, TIME_MAX, '0, '0);
        send(CMD_ADD, 6'd63, 64'd5, '0, '0);
        send(CMD_ADD, 6'd0, 64'd0, '0, '0);
        send(CMD_ADD, 6'd7, 64'd0, '0, '0);
        send(CMD_SET, '0, '0, '0, 64'd3);
        send(CMD_CANCEL, 6'd7, '0, '0, '0);
        send(CMD_CANCEL, 6'd63, '0, '0, '0);
        for (int i = 1; i <= 16; i++)
            send(CMD_ADD, 6'(i + 20), 64'd10, '0, '0);
        send(CMD_ADD, 6'd50, 64'd1, '0, '0);
        send(CMD_WAKE, '0, '0, TIME_MAX, '0);
        send(CMD_WAKE, '0, '0, TIME_MAX, '0);
        send(CMD_SET, '0, '0, '0, TIME_MAX);
        send(CMD_WAKE, '0, '0, TIME_MAX, '0);
        // pause until every result is back
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        hold_cycles = 200;
        for (int i = 0; i < 370; i++)
        begin
            if (i >= 320)
                no_idle = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 45)
                send(CMD_ADD, 6'($urandom_range(0, 63)),
                     ($urandom_range(0, 15) == 0) ? rnd64() : near_time(), '0, '0);
            else if (r < 60)
                send(CMD_CANCEL, 6'($urandom_range(0, 63)), rnd64(), rnd64(), rnd64());
            else if (r < 85)
            begin
                clock_now = clock_now + $urandom_range(0, 40);
                t = ($urandom_range(0, 19) == 0) ? rnd64() : clock_now;
                send(CMD_WAKE, 6'($urandom()), rnd64(), t, rnd64());
            end
            else
                send(CMD_SET, 6'($urandom()), rnd64(),  rnd64(),
                     ($urandom_range(0, 4) == 0) ? rnd64() : near_time());
        end
        req.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        drain_done = 1'b1;
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
